// ===== hw/rtl/days_between_dates_unit_macros.svh =====
// Assertion macros for the day distance unit.
`ifndef DAYS_BETWEEN_DATES_UNIT_MACROS_SVH
`define DAYS_BETWEEN_DATES_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define DBD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DBD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DBD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DBD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/dbd_pkg.sv =====
// Shared constants, types and the month table of the day distance unit.
package dbd_pkg;

   localparam int MAX_YEAR_DEFAULT = 9999;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DIFF_W   = 23;
   localparam int DAYNUM_W = 23;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2**15
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   localparam int MONTH_FIRST = 1;
   localparam int MONTH_LAST  = 12;
   localparam int MONTH_FEB   = 2;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } dbd_stage_en_type;

   // days in the months before the month at index idx (0 is January), common year
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] idx);
      logic [8:0] days;
      case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== hw/rtl/dbd_day_number.sv =====
// Four-stage pipeline that maps one date to its day number.
module dbd_day_number #(
   parameter int MAX_YEAR = dbd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                                clock,
   input  dbd_pkg::dbd_stage_en_type           stage_en,
   input  logic [dbd_pkg::YEAR_W-1:0]          year,
   input  logic [dbd_pkg::MONTH_W-1:0]         month,
   input  logic [dbd_pkg::DAY_W-1:0]           day,
   output logic [dbd_pkg::DAYNUM_W-1:0]        day_num
);
   import dbd_pkg::*;

   localparam logic [16:0] MaxYearVal = 17'(MAX_YEAR);
   localparam int SumW   = YEAR_W + 1;
   localparam int Q4W    = SumW - 2;
   localparam int P100W  = SumW + 13;
   localparam int P400W  = Q4W + 13;
   localparam int PYW    = YEAR_W + 13;
   localparam int SmallW = 14;

   // stage 1: clamped date
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff;

   // stage 2: constant products and month offset
   logic [P100W-1:0]    prod100_ff, prod100_in;
   logic [P400W-1:0]    prod400_ff, prod400_in;
   logic [PYW-1:0]      prody_ff, prody_in;
   logic [DAYNUM_W-1:0] y365_ff, y365_in;
   logic [Q4W-1:0]      y4_ff, y4_in;
   logic [8:0]          mdays_ff, mdays_in;
   logic                late_ff, late_in;
   logic [YEAR_W-1:0]   year2_ff;

   // stage 3: small correction term
   logic [DAYNUM_W-1:0] y365_s3_ff;
   logic [SmallW-1:0]   small_ff, small_in;

   // stage 4: day number
   logic [DAYNUM_W-1:0] dnum_ff, dnum_in;

   logic [SumW-1:0]    sum99, sum399, sum3;
   logic [8:0]         q100;
   logic [6:0]         q400;
   logic [7:0]         yq;
   logic [SumW-1:0]    yq100;
   logic               leap;

   always_comb begin
      year_in = ({3'b000, year} > MaxYearVal) ? MaxYearVal[YEAR_W-1:0] : year;
      if (month < MONTH_W'(MONTH_FIRST)) begin
         month_in = MONTH_W'(MONTH_FIRST);
      end else if (month > MONTH_W'(MONTH_LAST)) begin
         month_in = MONTH_W'(MONTH_LAST);
      end else begin
         month_in = month;
      end
   end

   always_comb begin
      sum99      = {1'b0, year_ff} + SumW'(99);
      sum399     = {1'b0, year_ff} + SumW'(399);
      sum3       = {1'b0, year_ff} + SumW'(3);
      prod100_in = P100W'(sum99) * P100W'(RECIP_100);
      prod400_in = P400W'(sum399[SumW-1:2]) * P400W'(RECIP_100);
      prody_in   = PYW'(year_ff) * PYW'(RECIP_100);
      y365_in    = DAYNUM_W'(year_ff) * DAYNUM_W'(365);
      y4_in      = sum3[SumW-1:2];
      mdays_in   = days_before_month(month_ff - MONTH_W'(MONTH_FIRST)) + 9'(day_ff);
      late_in    = month_ff > MONTH_W'(MONTH_FEB);
   end

   always_comb begin
      q100  = prod100_ff[P100W-1:RECIP_SHIFT];
      q400  = prod400_ff[P400W-1:RECIP_SHIFT];
      yq    = prody_ff[PYW-1:RECIP_SHIFT];
      yq100 = SumW'(yq) * SumW'(100);
      // leap: divisible by 4, and not a century unless the century count is divisible by 4
      leap  = (year2_ff[1:0] == 2'b00)
              && ((SumW'(year2_ff) != yq100) || (yq[1:0] == 2'b00));
      small_in = SmallW'(y4_ff) - SmallW'(q100) + SmallW'(q400) + SmallW'(mdays_ff)
                 + SmallW'(late_ff && leap);
   end

   assign dnum_in = y365_s3_ff + DAYNUM_W'(small_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day;
      end
      if (stage_en.s2) begin
         prod100_ff <= prod100_in;
         prod400_ff <= prod400_in;
         prody_ff   <= prody_in;
         y365_ff    <= y365_in;
         y4_ff      <= y4_in;
         mdays_ff   <= mdays_in;
         late_ff    <= late_in;
         year2_ff   <= year_ff;
      end
      if (stage_en.s3) begin
         y365_s3_ff <= y365_ff;
         small_ff   <= small_in;
      end
      if (stage_en.s4) begin
         dnum_ff <= dnum_in;
      end
   end

   assign day_num = dnum_ff;

endmodule

// ===== hw/rtl/days_between_dates_unit.sv =====
// An accepted transaction passes through the day number stages and the difference register to the rsp_ ports.
// Throughput: one transaction per cycle; every stage has its own valid bit and
// a stage holds only while the stage after it is full and stalled.
// Reset (synchronous, active high) clears all stage valid bits; no data is cleared.
// Top level: signed day distance between two Gregorian dates.
`include "days_between_dates_unit_macros.svh"

module days_between_dates_unit #(
   parameter int MAX_YEAR = dbd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dbd_pkg::YEAR_W-1:0]          req_start_year,
   input  logic [dbd_pkg::MONTH_W-1:0]         req_start_month,
   input  logic [dbd_pkg::DAY_W-1:0]           req_start_day,
   input  logic [dbd_pkg::YEAR_W-1:0]          req_end_year,
   input  logic [dbd_pkg::MONTH_W-1:0]         req_end_month,
   input  logic [dbd_pkg::DAY_W-1:0]           req_end_day,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dbd_pkg::DIFF_W-1:0]   rsp_day_difference
);
   import dbd_pkg::*;

   localparam int WideW = DAYNUM_W + 1;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic             rdy1, rdy2, rdy3, rdy4, rdy5;
   dbd_stage_en_type stage_en;

   logic [DAYNUM_W-1:0]      start_num, end_num;
   logic signed [WideW-1:0]  diff;
   logic signed [DIFF_W-1:0] diff_out_ff, diff_out_in;

   // a stage takes new data when it is empty or its contents move on
   always_comb begin
      rdy5 = !v5_ff || rsp_ready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      stage_en.s1 = rdy1;
      stage_en.s2 = rdy2;
      stage_en.s3 = rdy3;
      stage_en.s4 = rdy4;
   end

   assign req_ready = rdy1;

   dbd_day_number #(.MAX_YEAR(MAX_YEAR)) u_start (
      .clock    (clock),
      .stage_en (stage_en),
      .year     (req_start_year),
      .month    (req_start_month),
      .day      (req_start_day),
      .day_num  (start_num)
   );

   dbd_day_number #(.MAX_YEAR(MAX_YEAR)) u_end (
      .clock    (clock),
      .stage_en (stage_en),
      .year     (req_end_year),
      .month    (req_end_month),
      .day      (req_end_day),
      .day_num  (end_num)
   );

   // saturate when the two top bits of the wide difference disagree
   always_comb begin
      diff = $signed({1'b0, end_num}) - $signed({1'b0, start_num});
      if (diff[WideW-1] != diff[WideW-2]) begin
         diff_out_in = diff[WideW-1] ? {1'b1, {(DIFF_W-1){1'b0}}}
                                     : {1'b0, {(DIFF_W-1){1'b1}}};
      end else begin
         diff_out_in = diff[DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         diff_out_ff <= diff_out_in;
      end
   end

   assign rsp_valid          = v5_ff;
   assign rsp_day_difference = diff_out_ff;

   `DBD_ASSERT_IMP(a_full_when_blocked, clock, reset, !req_ready, v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_ready, "input blocked while pipeline not full")
   `DBD_ASSERT_NXT(a_drain_empty, clock, reset, rsp_valid && rsp_ready && !v4_ff, !rsp_valid, "result appeared with no transaction behind it")
   `DBD_ASSERT_NXT(a_stall_holds, clock, reset, v3_ff && !rdy3, v3_ff && v4_ff && v5_ff, "stalled transaction lost")
   `DBD_ASSERT_NXT(a_result_moves, clock, reset, v4_ff && rdy5, rsp_valid, "transaction dropped before output")

endmodule
